[src/mmie_pkg.sv]
// Package: opcodes, fault codes, queue entry and sequencer states for the executor.
`timescale 1ns / 1ps
package mmie_pkg;
  localparam int unsigned DataDepthDef = 256;
  localparam int unsigned ProgDepthDef = 256;
  localparam int unsigned WordWidthDef = 32;
  localparam int unsigned KindW = 5;
  localparam int unsigned ArgW = 8;
  localparam int unsigned ImmW = 32;
  localparam int unsigned FaultW = 2;
  localparam int unsigned CountW = 32;

  localparam logic [KindW-1:0] OpSet   = 5'd0;
  localparam logic [KindW-1:0] OpSeta  = 5'd1;
  localparam logic [KindW-1:0] OpCopy  = 5'd2;
  localparam logic [KindW-1:0] OpCopya = 5'd3;
  localparam logic [KindW-1:0] OpAdd   = 5'd4;
  localparam logic [KindW-1:0] OpSub   = 5'd5;
  localparam logic [KindW-1:0] OpMult  = 5'd6;
  localparam logic [KindW-1:0] OpDiv   = 5'd7;
  localparam logic [KindW-1:0] OpJump  = 5'd8;
  localparam logic [KindW-1:0] OpJumpa = 5'd9;
  localparam logic [KindW-1:0] OpBeq   = 5'd10;
  localparam logic [KindW-1:0] OpBeqa  = 5'd11;
  localparam logic [KindW-1:0] OpBlt   = 5'd12;
  localparam logic [KindW-1:0] OpBlta  = 5'd13;
  localparam logic [KindW-1:0] OpBgt   = 5'd14;
  localparam logic [KindW-1:0] OpBgta  = 5'd15;
  localparam logic [KindW-1:0] OpEnd   = 5'd16;

  localparam logic [FaultW-1:0] FaultNone   = 2'd0;
  localparam logic [FaultW-1:0] FaultOpcode = 2'd1;
  localparam logic [FaultW-1:0] FaultDivZ   = 2'd2;

  typedef enum logic [1:0] {
    ClsStore,
    ClsArith,
    ClsFlow,
    ClsStop
  } cls_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    cls_e             cls;
    logic [ArgW-1:0]  arg_a;
    logic [ImmW-1:0]  arg_b;
    logic [ArgW-1:0]  arg_c;
  } instr_t;

  typedef enum logic [3:0] {
    StIdle,
    StRdA,
    StRdB,
    StRdC,
    StRdX,
    StMul,
    StDiv,
    StFix,
    StWrite,
    StOut
  } exec_st_e;
endpackage

[src/memory_to_memory_instruction_executor.sv]
// Top level: memory-to-memory instruction executor with decoupled front and back.
`timescale 1ns / 1ps
// Instructions enter on the s_axis channel: tuser holds the opcode, tdata the
// operands. Each transfer yields one status transfer on m_axis: the next
// program counter, the halt mark, the fault code and the executed count.
// A two-entry queue separates the decoder from the execution sequencer.
// Each instruction steps from the queue pop through any store reads, any
// arithmetic and any store write to its status; the single-port data store
// read, one access a cycle, orders the operand reads of indirect forms.
// One instruction executes at a time.
// After reset the data store is cleared, one entry a cycle, until every
// entry is zero; instructions wait in the queue meanwhile.
// When the receiver stalls, the status stays on m_axis and the sequencer
// holds; the queue fills and then s_axis_tready drops.
// Once halted, instructions are taken and answered with the held status.
module memory_to_memory_instruction_executor
  import mmie_pkg::*;
#(
  parameter int unsigned DATA_DEPTH = DataDepthDef,
  parameter int unsigned PROG_DEPTH = ProgDepthDef,
  parameter int unsigned WORD_WIDTH = WordWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [55:0]      s_axis_tdata,  // arg_a, arg_b, arg_c, zero fill
  input  logic [KindW-1:0] s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [47:0]      m_axis_tdata   // next_address, halted, fault, executed count
);
  logic       q_valid, q_ready;
  instr_t     q_data;
  logic [ArgW-1:0]   pc;
  logic              halted;
  logic [FaultW-1:0] fault;
  logic [CountW-1:0] count;

  mmie_decode u_dec (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  mmie_execute #(
    .DataDepth(DATA_DEPTH), .ProgDepth(PROG_DEPTH), .WordWidth(WORD_WIDTH)
  ) u_exe (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .pc_o(pc), .halted_o(halted), .fault_o(fault), .count_o(count)
  );

  assign m_axis_tdata = {5'd0, count, fault, halted, pc};

  a_fault_needs_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault != FaultNone) |-> halted) else $error("fault without halt");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted |=> halted) else $error("halt cleared");
  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count != $past(count)) |-> (count == $past(count) + 32'd1))
    else $error("count jumped");
endmodule

[src/mmie_decode.sv]
// Front part: accepts instructions, classifies them and queues them for execution.
`timescale 1ns / 1ps
module mmie_decode
  import mmie_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [55:0]          s_axis_tdata,
  input  logic [KindW-1:0]     s_axis_tuser,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output instr_t               q_data_o
);
  instr_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  instr_t     in_w;
  logic       push, pop;

  always_comb begin
    in_w.kind  = s_axis_tuser;
    in_w.arg_a = s_axis_tdata[7:0];
    in_w.arg_b = s_axis_tdata[39:8];
    in_w.arg_c = s_axis_tdata[47:40];
    if (s_axis_tuser <= OpCopya) begin
      in_w.cls = ClsStore;
    end else if (s_axis_tuser <= OpDiv) begin
      in_w.cls = ClsArith;
    end else if (s_axis_tuser <= OpBgta) begin
      in_w.cls = ClsFlow;
    end else begin
      in_w.cls = ClsStop;
    end
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push = s_axis_tvalid && s_axis_tready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[src/mmie_divider.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module mmie_divider
  import mmie_pkg::*;
#(
  parameter int unsigned WordWidth = WordWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WordWidth-1:0] num_i,
  input  logic [WordWidth-1:0] den_i,
  output logic                 done_o,
  output logic [WordWidth-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(WordWidth + 1);
  logic [WordWidth-1:0] quo_q, den_q;
  logic [WordWidth:0]   rem_q;
  logic [CntW-1:0]      cnt_q;
  logic                 neg_q, busy_q;
  logic [WordWidth:0]   shifted, diff;

  assign shifted = {rem_q[WordWidth-1:0], quo_q[WordWidth-1]};
  assign diff = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CntW'(WordWidth);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i[WordWidth-1] ? (~num_i + 1'b1) : num_i;
      den_q <= den_i[WordWidth-1] ? (~den_i + 1'b1) : den_i;
      rem_q <= '0;
      neg_q <= num_i[WordWidth-1] ^ den_i[WordWidth-1];
    end else if (busy_q) begin
      if (!diff[WordWidth]) begin
        rem_q <= diff;
        quo_q <= {quo_q[WordWidth-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[WordWidth-2:0], 1'b0};
      end
    end
  end

  assign quo_o = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

[src/mmie_execute.sv]
// Back part: sequences store reads, arithmetic, store write and result transfer.
`timescale 1ns / 1ps
module mmie_execute
  import mmie_pkg::*;
#(
  parameter int unsigned DataDepth = DataDepthDef,
  parameter int unsigned ProgDepth = ProgDepthDef,
  parameter int unsigned WordWidth = WordWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  instr_t                     q_data_i,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [ArgW-1:0]            pc_o,
  output logic                       halted_o,
  output logic [FaultW-1:0]          fault_o,
  output logic [CountW-1:0]          count_o
);
  localparam int unsigned DaW = $clog2(DataDepth);
  localparam int unsigned PaW = $clog2(ProgDepth);
  localparam int unsigned ClrW = DaW + 1;

  exec_st_e state_q, state_d;
  instr_t   ins_q;
  logic [WordWidth-1:0] mem [DataDepth];
  logic [WordWidth-1:0] rdata_q, x_q, y_q, res_q;
  logic [DaW-1:0]       raddr, waddr_q;
  logic                 re, we;
  logic [WordWidth-1:0] wdata;
  logic [PaW-1:0]       pc_q;
  logic [CountW-1:0]    cnt_q;
  logic                 stop_q;
  logic [FaultW-1:0]    fault_q;
  logic [ClrW-1:0]      clr_q;
  logic                 clearing;
  logic [2*WordWidth-1:0] prod_q;
  logic                 div_start, div_done;
  logic [WordWidth-1:0] quo;
  logic [WordWidth-1:0] imm;
  logic                 take;
  logic                 rd_first;

  assign clearing = !clr_q[DaW];
  assign imm = WordWidth'({{32{q_data_i.arg_b[ImmW-1]}}, q_data_i.arg_b});

  mmie_divider #(.WordWidth(WordWidth)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(x_q), .den_i(rdata_q),
    .done_o(div_done), .quo_o(quo)
  );

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr_q] <= wdata;
    if (clearing) mem[clr_q[DaW-1:0]] <= '0;
    if (re) rdata_q <= mem[raddr];
  end

  always_comb begin
    unique case (ins_q.kind)
      OpBeq, OpBeqa: take = (x_q == rdata_q);
      OpBlt, OpBlta: take = ($signed(x_q) < $signed(rdata_q));
      default:       take = ($signed(rdata_q) < $signed(x_q));
    endcase
  end

  assign rd_first = (q_data_i.kind == OpSeta) || (q_data_i.kind == OpJumpa) ||
                    (q_data_i.kind == OpCopy) || (q_data_i.kind == OpCopya) ||
                    (q_data_i.cls == ClsArith) ||
                    ((q_data_i.cls == ClsFlow) && (q_data_i.kind != OpJump));

  always_comb begin
    state_d = state_q;
    q_ready_o = 1'b0;
    re = 1'b0;
    raddr = DaW'(ins_q.arg_a);
    we = 1'b0;
    wdata = res_q;
    div_start = 1'b0;
    m_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        q_ready_o = !clearing;
        raddr = DaW'(q_data_i.arg_a);
        re = q_valid_i && !clearing && !stop_q && rd_first;
        if (q_valid_i && !clearing) begin
          if (stop_q) begin
            state_d = StOut;
          end else if (q_data_i.kind == OpSet) begin
            state_d = StWrite;
          end else if (rd_first) begin
            state_d = StRdA;
          end else begin
            state_d = StOut;
          end
        end
      end
      StRdA: begin
        priority if (ins_q.kind == OpSeta || ins_q.kind == OpJumpa) begin
          state_d = (ins_q.kind == OpSeta) ? StWrite : StOut;
        end else if (ins_q.kind == OpCopy) begin
          state_d = StWrite;
        end else begin
          re = 1'b1;
          raddr = DaW'(ins_q.arg_b);
          state_d = StRdB;
        end
      end
      StRdB: begin
        priority if (ins_q.kind == OpCopya) begin
          state_d = StWrite;
        end else if (ins_q.kind == OpMult) begin
          state_d = StMul;
        end else if (ins_q.kind == OpDiv) begin
          div_start = (rdata_q != '0);
          state_d = (rdata_q != '0) ? StDiv : StWrite;
        end else if (ins_q.cls == ClsArith) begin
          state_d = StWrite;
        end else if (take && ins_q.kind[0]) begin
          re = 1'b1;
          raddr = DaW'(ins_q.arg_c);
          state_d = StRdC;
        end else begin
          state_d = StOut;
        end
      end
      StRdC: state_d = StOut;
      StMul: state_d = StFix;
      StDiv: if (div_done) state_d = StWrite;
      StFix: state_d = StWrite;
      StWrite: begin
        we = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        m_valid_o = 1'b1;
        if (m_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pc_q <= '0;
      cnt_q <= '0;
      stop_q <= 1'b0;
      fault_q <= FaultNone;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_q <= clr_q + 1'b1;
      if (state_q == StIdle && q_valid_i && !clearing && !stop_q) begin
        if (q_data_i.cls == ClsStop) begin
          stop_q <= 1'b1;
          fault_q <= (q_data_i.kind == OpEnd) ? FaultNone : FaultOpcode;
        end else begin
          cnt_q <= cnt_q + 1'b1;
          pc_q <= (q_data_i.kind == OpJump) ? PaW'(q_data_i.arg_a) : pc_q + 1'b1;
        end
      end
      if (state_q == StRdA && ins_q.kind == OpJumpa) pc_q <= PaW'(rdata_q);
      if (state_q == StRdB && ins_q.cls == ClsFlow && take && !ins_q.kind[0]) begin
        pc_q <= PaW'(ins_q.arg_c);
      end
      if (state_q == StRdC) pc_q <= PaW'(rdata_q);
      if (state_q == StRdB && ins_q.kind == OpDiv && rdata_q == '0) begin
        stop_q <= 1'b1;
        fault_q <= FaultDivZ;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_valid_i) begin
      ins_q <= q_data_i;
      res_q <= imm;
      waddr_q <= DaW'(q_data_i.arg_a);
    end
    if (state_q == StRdA) begin
      x_q <= rdata_q;
      if (ins_q.kind == OpSeta) waddr_q <= DaW'(rdata_q);
      if (ins_q.kind == OpCopy) begin
        waddr_q <= DaW'(ins_q.arg_b);
        res_q <= rdata_q;
      end
    end
    if (state_q == StRdB) begin
      y_q <= rdata_q;
      waddr_q <= (ins_q.kind == OpCopya) ? DaW'(rdata_q) : DaW'(ins_q.arg_c);
      unique case (ins_q.kind)
        OpCopya: res_q <= x_q;
        OpAdd:   res_q <= x_q + rdata_q;
        OpSub:   res_q <= x_q - rdata_q;
        default: res_q <= '0;
      endcase
    end
    if (state_q == StMul) prod_q <= (2*WordWidth)'(x_q) * (2*WordWidth)'(y_q);
    if (state_q == StFix) res_q <= prod_q[WordWidth-1:0];
    if (state_q == StDiv && div_done) res_q <= quo;
  end

  assign pc_o = ArgW'(pc_q);
  assign halted_o = stop_q;
  assign fault_o = fault_q;
  assign count_o = cnt_q;
endmodule
